@@ hw/rtl/qmsm_pkg.sv @@
`default_nettype none
package qmsm_pkg;

	// Field widths fixed by the register map.
	localparam int FLOOR_BITS    = 11;
	localparam int HOVER_BITS    = 12;
	localparam int GAIN_BITS     = 16;
	localparam int DIFF_BITS     = 13;
	localparam int DD_BITS       = 24;
	localparam int BASE_BITS     = 32;
	localparam int Q_FRAC_BITS   = 8;
	localparam int FRAC_SHIFT    = 4;
	localparam int CFG_DATA_BITS = 16;
	localparam int REG_IDX_BITS  = 3;

	// Defaults for the top-level parameters.
	localparam int CMD_BITS_DEF  = 16;
	localparam int DUTY_BITS_DEF = 12;

	// Root bits resolved per square-root stage.
	localparam int SQRT_STEPS = 2;

	localparam int NUM_AXES   = 3;
	localparam int NUM_LANES  = 2 * NUM_AXES;
	localparam int NUM_MOTORS = 4;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_DUTY_FLOOR = 3'd0,
		REG_DUTY_HOVER = 3'd1,
		REG_GAIN_PITCH = 3'd2,
		REG_GAIN_ROLL  = 3'd3,
		REG_GAIN_YAW   = 3'd4
	} reg_idx_t;

	localparam logic [FLOOR_BITS-1:0] FLOOR_RST = 11'd1024;
	localparam logic [HOVER_BITS-1:0] HOVER_RST = 12'd1300;
	localparam logic [GAIN_BITS-1:0]  GAIN_RST  = 16'd256;

	typedef struct packed {
		logic [FLOOR_BITS-1:0] duty_floor;
		logic [HOVER_BITS-1:0] duty_hover;
		logic [GAIN_BITS-1:0]  gain_pitch;
		logic [GAIN_BITS-1:0]  gain_roll;
		logic [GAIN_BITS-1:0]  gain_yaw;
	} cfg_t;

	// Thrust lanes: two per axis, positive sign first.
	localparam int LANE_P_POS = 0;
	localparam int LANE_P_NEG = 1;
	localparam int LANE_R_POS = 2;
	localparam int LANE_R_NEG = 3;
	localparam int LANE_Y_POS = 4;
	localparam int LANE_Y_NEG = 5;

	// X-frame mix: lanes summed for each motor (pitch, roll, yaw).
	localparam int MIX_LANE [NUM_MOTORS][NUM_AXES] = '{
		'{LANE_P_POS, LANE_R_POS, LANE_Y_NEG},
		'{LANE_P_POS, LANE_R_NEG, LANE_Y_POS},
		'{LANE_P_NEG, LANE_R_POS, LANE_Y_POS},
		'{LANE_P_NEG, LANE_R_NEG, LANE_Y_NEG}
	};

	function automatic int max2(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

	// Signed gain * command product.
	function automatic int prod_bits(input int cmd_bits);
		return GAIN_BITS + cmd_bits;
	endfunction

	// Signed radicand (base +/- product).
	function automatic int rad_sbits(input int cmd_bits);
		return max2(prod_bits(cmd_bits), BASE_BITS + 1) + 1;
	endfunction

	// Non-negative radicand after the clamp at zero.
	function automatic int rad_bits(input int cmd_bits);
		return rad_sbits(cmd_bits) - 1;
	endfunction

	function automatic int sqrt_stages(input int cmd_bits);
		return ((rad_bits(cmd_bits) + 1) / 2 + SQRT_STEPS - 1) / SQRT_STEPS;
	endfunction

	function automatic int root_pad(input int cmd_bits);
		return sqrt_stages(cmd_bits) * SQRT_STEPS;
	endfunction

	function automatic int term_bits(input int cmd_bits);
		return root_pad(cmd_bits) - FRAC_SHIFT;
	endfunction

	function automatic int sum_bits(input int cmd_bits, input int duty_bits);
		return max2(max2(term_bits(cmd_bits), duty_bits), DIFF_BITS) + 4;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/qmsm_if.sv @@
`default_nettype none
interface qmsm_cmd_if #(
	parameter int CMD_BITS = qmsm_pkg::CMD_BITS_DEF
);
	logic                       valid;
	logic                       ready;
	logic signed [CMD_BITS-1:0] pitch_cmd;
	logic signed [CMD_BITS-1:0] roll_cmd;
	logic signed [CMD_BITS-1:0] yaw_cmd;

	modport source (output valid, output pitch_cmd, output roll_cmd, output yaw_cmd,
		input ready);
	modport sink (input valid, input pitch_cmd, input roll_cmd, input yaw_cmd,
		output ready);
endinterface

interface qmsm_duty_if #(
	parameter int DUTY_BITS = qmsm_pkg::DUTY_BITS_DEF
);
	logic                 valid;
	logic                 ready;
	logic [DUTY_BITS-1:0] duty_front_left;
	logic [DUTY_BITS-1:0] duty_rear_left;
	logic [DUTY_BITS-1:0] duty_front_right;
	logic [DUTY_BITS-1:0] duty_rear_right;

	modport source (output valid, output duty_front_left, output duty_rear_left,
		output duty_front_right, output duty_rear_right, input ready);
	modport sink (input valid, input duty_front_left, input duty_rear_left,
		input duty_front_right, input duty_rear_right, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/qmsm_front.sv @@
`default_nettype none
module qmsm_front #(
	parameter int CMD_BITS = qmsm_pkg::CMD_BITS_DEF,
	localparam int RAD_BITS = qmsm_pkg::rad_bits(CMD_BITS)
) (
	input  wire logic                       clk,
	input  wire logic                       adv,
	input  wire qmsm_pkg::cfg_t             cfg,
	input  wire logic signed [CMD_BITS-1:0] pitch_cmd,
	input  wire logic signed [CMD_BITS-1:0] roll_cmd,
	input  wire logic signed [CMD_BITS-1:0] yaw_cmd,
	output logic [RAD_BITS-1:0]             rad [qmsm_pkg::NUM_LANES]
);
	import qmsm_pkg::*;

	localparam int PROD_BITS = prod_bits(CMD_BITS);
	localparam int RAD_SBITS = rad_sbits(CMD_BITS);

	logic signed [DIFF_BITS-1:0]   diff;
	logic signed [2*DIFF_BITS-1:0] dd_full;
	logic [DD_BITS-1:0]            dd_s1;
	logic signed [CMD_BITS-1:0]    cmd_v  [NUM_AXES];
	logic [GAIN_BITS-1:0]          gain_v [NUM_AXES];
	logic signed [PROD_BITS-1:0]   prod_s1 [NUM_AXES];
	logic signed [RAD_SBITS-1:0]   base_x;

	assign diff    = $signed({1'b0, cfg.duty_hover}) - $signed({2'b00, cfg.duty_floor});
	assign dd_full = diff * diff;

	assign cmd_v[0]  = pitch_cmd;
	assign cmd_v[1]  = roll_cmd;
	assign cmd_v[2]  = yaw_cmd;
	assign gain_v[0] = cfg.gain_pitch;
	assign gain_v[1] = cfg.gain_roll;
	assign gain_v[2] = cfg.gain_yaw;

	// Stage 1: hover offset squared and one gain product per axis.
	always_ff @(posedge clk) begin
		if (adv) begin
			dd_s1 <= dd_full[DD_BITS-1:0];
		end
	end

	assign base_x = $signed(RAD_SBITS'({dd_s1, {Q_FRAC_BITS{1'b0}}}));

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		logic signed [PROD_BITS-1:0] prod_full;
		logic signed [RAD_SBITS-1:0] prod_x;
		logic signed [RAD_SBITS-1:0] r_pos;
		logic signed [RAD_SBITS-1:0] r_neg;

		assign prod_full = $signed({1'b0, gain_v[a]}) * cmd_v[a];

		always_ff @(posedge clk) begin
			if (adv) begin
				prod_s1[a] <= prod_full;
			end
		end

		// Stage 2: radicands for both signs, negative ones drop to zero.
		assign prod_x = RAD_SBITS'(prod_s1[a]);
		assign r_pos  = base_x + prod_x;
		assign r_neg  = base_x - prod_x;

		always_ff @(posedge clk) begin
			if (adv) begin
				rad[2*a]   <= (r_pos > 0) ? r_pos[RAD_BITS-1:0] : '0;
				rad[2*a+1] <= (r_neg > 0) ? r_neg[RAD_BITS-1:0] : '0;
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/qmsm_sqrt.sv @@
`default_nettype none
module qmsm_sqrt #(
	parameter int CMD_BITS = qmsm_pkg::CMD_BITS_DEF,
	localparam int RAD_BITS  = qmsm_pkg::rad_bits(CMD_BITS),
	localparam int TERM_BITS = qmsm_pkg::term_bits(CMD_BITS)
) (
	input  wire logic                 clk,
	input  wire logic                 adv,
	input  wire logic [RAD_BITS-1:0]  rad,
	output logic [TERM_BITS-1:0]      term
);
	import qmsm_pkg::*;

	localparam int NSTG = sqrt_stages(CMD_BITS);
	localparam int RP   = root_pad(CMD_BITS);
	localparam int NW   = 2 * RP;
	localparam int RW   = RP + 2;

	logic [NW-1:0] n_s    [NSTG];
	logic [RW-1:0] rem_s  [NSTG];
	logic [RP-1:0] root_s [NSTG];

	// Digit-by-digit square root, SQRT_STEPS root bits per stage.
	for (genvar st = 0; st < NSTG; st++) begin : g_stg
		logic [NW-1:0] n_i;
		logic [RW-1:0] rem_i;
		logic [RP-1:0] root_i;
		logic [NW-1:0] n_o;
		logic [RW-1:0] rem_o;
		logic [RP-1:0] root_o;

		if (st == 0) begin : g_first
			assign n_i    = NW'(rad);
			assign rem_i  = '0;
			assign root_i = '0;
		end else begin : g_next
			assign n_i    = n_s[st-1];
			assign rem_i  = rem_s[st-1];
			assign root_i = root_s[st-1];
		end

		always_comb begin
			logic [RW-1:0] trial;
			n_o    = n_i;
			rem_o  = rem_i;
			root_o = root_i;
			for (int k = 0; k < SQRT_STEPS; k++) begin
				rem_o = {rem_o[RW-3:0], n_o[NW-1 -: 2]};
				n_o   = n_o << 2;
				trial = {root_o, 2'b01};
				if (rem_o >= trial) begin
					rem_o  = rem_o - trial;
					root_o = {root_o[RP-2:0], 1'b1};
				end else begin
					root_o = {root_o[RP-2:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				root_s[st] <= root_o;
			end
		end

		// The last stage keeps only the root.
		if (st < NSTG - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (adv) begin
					n_s[st]   <= n_o;
					rem_s[st] <= rem_o;
				end
			end
		end else begin : g_tail
			assign n_s[st]   = '0;
			assign rem_s[st] = '0;
		end
	end

	// Drop the Q8.8 fraction: sqrt(x * 256) carries four fraction bits.
	assign term = root_s[NSTG-1][RP-1:FRAC_SHIFT];

endmodule
`default_nettype wire

@@ hw/rtl/qmsm_merge.sv @@
`default_nettype none
module qmsm_merge #(
	parameter int CMD_BITS  = qmsm_pkg::CMD_BITS_DEF,
	parameter int DUTY_BITS = qmsm_pkg::DUTY_BITS_DEF,
	localparam int TERM_BITS = qmsm_pkg::term_bits(CMD_BITS)
) (
	input  wire logic                              clk,
	input  wire logic                              adv,
	input  wire logic [qmsm_pkg::FLOOR_BITS-1:0]   duty_floor,
	input  wire logic [qmsm_pkg::HOVER_BITS-1:0]   duty_hover,
	input  wire logic [TERM_BITS-1:0]              term [qmsm_pkg::NUM_LANES],
	output logic [DUTY_BITS-1:0]                   duty [qmsm_pkg::NUM_MOTORS]
);
	import qmsm_pkg::*;

	localparam int SUM_BITS = sum_bits(CMD_BITS, DUTY_BITS);

	logic signed [SUM_BITS-1:0] fl_x;
	logic signed [SUM_BITS-1:0] hv_x;
	logic signed [SUM_BITS-1:0] offset;
	logic signed [SUM_BITS-1:0] lo;
	logic signed [SUM_BITS-1:0] hi;
	logic signed [SUM_BITS-1:0] dmax;
	logic signed [SUM_BITS-1:0] sum_s1 [NUM_MOTORS];

	// Each term carries one duty_floor; the motor sum removes 2*hover.
	assign fl_x   = $signed(SUM_BITS'(duty_floor));
	assign hv_x   = $signed(SUM_BITS'(duty_hover));
	assign offset = fl_x + fl_x + fl_x - hv_x - hv_x;
	assign lo     = fl_x;
	assign hi     = fl_x + fl_x;
	assign dmax   = $signed(SUM_BITS'({DUTY_BITS{1'b1}}));

	for (genvar m = 0; m < NUM_MOTORS; m++) begin : g_motor
		logic signed [SUM_BITS-1:0] sum_c;
		logic signed [SUM_BITS-1:0] sat;

		assign sum_c = $signed(SUM_BITS'(term[MIX_LANE[m][0]]))
			+ $signed(SUM_BITS'(term[MIX_LANE[m][1]]))
			+ $signed(SUM_BITS'(term[MIX_LANE[m][2]]))
			+ offset;

		always_ff @(posedge clk) begin
			if (adv) begin
				sum_s1[m] <= sum_c;
			end
		end

		// Saturate to the duty range, clamp to [floor, 2*floor], saturate again.
		always_comb begin
			sat = sum_s1[m];
			if (sat < 0) begin
				sat = '0;
			end
			if (sat > dmax) begin
				sat = dmax;
			end
			if (sat > hi) begin
				sat = hi;
			end else if (sat < lo) begin
				sat = lo;
			end
			if (sat > dmax) begin
				sat = dmax;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				duty[m] <= sat[DUTY_BITS-1:0];
			end
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/quad_motor_sqrt_mixer_core.sv @@
// X-frame quadcopter motor mixer with square-root thrust terms.
//
// Channels: cmd (sink) takes one word of pitch, roll and yaw torque
// commands; duty (source) gives one word of four clamped motor duties per
// command word, in order. Configuration goes through cfg_we / cfg_idx /
// cfg_wdata (floor, hover, three Q8.8 gains); write it only while idle.
//
// Throughput: one word per cycle unless the output stalls. Six thrust
// lanes (two per axis) each run a pipelined square root that resolves
// two root bits per stage, and a two-stage merge sums, saturates and
// clamps the four motors. The radicand width is GAIN 16 + CMD_BITS,
// at least 33 bits.
//
// Stall: the pipeline advances as one. While the output word waits on
// duty.ready every stage holds and cmd.ready drops; an empty output stage
// or a taken output word lets the next word in. Inner bubbles stay put.
// Reset: the pipeline empties and the registers take their reset values
// (floor 1024, hover 1300, gains 1.0).
`default_nettype none
module quad_motor_sqrt_mixer_core #(
	parameter int CMD_BITS  = qmsm_pkg::CMD_BITS_DEF,
	parameter int DUTY_BITS = qmsm_pkg::DUTY_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [qmsm_pkg::REG_IDX_BITS-1:0]   cfg_idx,
	input  wire logic [qmsm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	qmsm_cmd_if.sink                                 cmd,
	qmsm_duty_if.source                              duty
);
	import qmsm_pkg::*;

	localparam int RAD_BITS  = rad_bits(CMD_BITS);
	localparam int TERM_BITS = term_bits(CMD_BITS);
	localparam int LAT       = 4 + sqrt_stages(CMD_BITS);

	cfg_t                 cfg_q;
	logic [LAT-1:0]       vld_q;
	logic                 adv;
	logic [RAD_BITS-1:0]  rad  [NUM_LANES];
	logic [TERM_BITS-1:0] term [NUM_LANES];
	logic [DUTY_BITS-1:0] duty_w [NUM_MOTORS];

	// Register file: out-of-range indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_floor <= FLOOR_RST;
			cfg_q.duty_hover <= HOVER_RST;
			cfg_q.gain_pitch <= GAIN_RST;
			cfg_q.gain_roll  <= GAIN_RST;
			cfg_q.gain_yaw   <= GAIN_RST;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_idx))
				REG_DUTY_FLOOR: cfg_q.duty_floor <= cfg_wdata[FLOOR_BITS-1:0];
				REG_DUTY_HOVER: cfg_q.duty_hover <= cfg_wdata[HOVER_BITS-1:0];
				REG_GAIN_PITCH: cfg_q.gain_pitch <= cfg_wdata[GAIN_BITS-1:0];
				REG_GAIN_ROLL:  cfg_q.gain_roll  <= cfg_wdata[GAIN_BITS-1:0];
				REG_GAIN_YAW:   cfg_q.gain_yaw   <= cfg_wdata[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Advance every stage unless the output word is blocked.
	assign adv       = !vld_q[LAT-1] || duty.ready;
	assign cmd.ready = adv;
	assign duty.valid = vld_q[LAT-1];

	// Occupancy follows the data through the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[LAT-2:0], cmd.valid};
		end
	end

	qmsm_front #(
		.CMD_BITS (CMD_BITS)
	) u_front (
		.clk       (clk),
		.adv       (adv),
		.cfg       (cfg_q),
		.pitch_cmd (cmd.pitch_cmd),
		.roll_cmd  (cmd.roll_cmd),
		.yaw_cmd   (cmd.yaw_cmd),
		.rad       (rad)
	);

	// One square-root pipeline per thrust term.
	for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
		qmsm_sqrt #(
			.CMD_BITS (CMD_BITS)
		) u_sqrt (
			.clk  (clk),
			.adv  (adv),
			.rad  (rad[l]),
			.term (term[l])
		);
	end

	qmsm_merge #(
		.CMD_BITS  (CMD_BITS),
		.DUTY_BITS (DUTY_BITS)
	) u_merge (
		.clk        (clk),
		.adv        (adv),
		.duty_floor (cfg_q.duty_floor),
		.duty_hover (cfg_q.duty_hover),
		.term       (term),
		.duty       (duty_w)
	);

	assign duty.duty_front_left  = duty_w[0];
	assign duty.duty_rear_left   = duty_w[1];
	assign duty.duty_front_right = duty_w[2];
	assign duty.duty_rear_right  = duty_w[3];

	// A blocked output word stalls the whole pipeline, input included.
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		duty.valid && !duty.ready |-> !cmd.ready)
		else $error("input taken while output word is blocked");

	// Occupancy must not move while stalled.
	a_stall_holds_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(vld_q))
		else $error("pipeline occupancy changed during stall");

	// An accepted word enters the first stage.
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.valid && cmd.ready |=> vld_q[0])
		else $error("accepted word lost at pipeline entry");

endmodule
`default_nettype wire
